@@ src/elevator_request_scheduler_unit_macros.svh @@
// Assertion macros for the elevator request scheduler.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ELEVATOR_REQUEST_SCHEDULER_UNIT_MACROS_SVH
`define ELEVATOR_REQUEST_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ERSU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ersu assertion failed");

// Next-cycle implication, checked out of reset
`define ERSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ersu assertion failed");

`endif

@@ src/ersu_pkg.sv @@
// Shared types and codes for the elevator request scheduler.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ersu_pkg;

  localparam int DEFAULT_FLOORS = 4;
  localparam int FLOOR_BITS     = 4;
  localparam int DIR_BITS       = 2;
  localparam int KIND_BITS      = 3;

  // item kinds as they arrive on the input channel
  localparam logic [KIND_BITS-1:0] KIND_CABIN = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_UP    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_DOWN  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_SCHED = 3'd4;

  // travel directions
  localparam logic [DIR_BITS-1:0] TRAVEL_IDLE = 2'd0;
  localparam logic [DIR_BITS-1:0] TRAVEL_UP   = 2'd1;
  localparam logic [DIR_BITS-1:0] TRAVEL_DOWN = 2'd2;

  // classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CABIN,
    OP_UP,
    OP_DOWN,
    OP_CLEAR,
    OP_SCHED
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [FLOOR_BITS-1:0] floor;
    logic [DIR_BITS-1:0]   dir;
  } cmd_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

@@ src/ersu_front.sv @@
// Front end: takes input beats and classifies them into queue commands.
// Depends on ersu_pkg.
`timescale 1ns / 1ps

module ersu_front #(
  parameter int FLOORS = ersu_pkg::DEFAULT_FLOORS
) (
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [3:0] floor, [5:4] direction_in, [7:6] zero
  input  logic [2:0]             in_tuser,   // [2:0] kind
  input  ersu_pkg::queue_stat_t  q_stat,
  output logic                   push,
  output ersu_pkg::cmd_t         push_cmd
);

  localparam logic [4:0] FLOORS_V = 5'(FLOORS);

  logic [3:0] fl;
  logic [1:0] dir;
  logic       in_range;
  logic       up_ok;
  logic       dn_ok;

  assign fl  = in_tdata[3:0];
  assign dir = in_tdata[5:4];

  // floor validity for each request kind
  assign in_range = {1'b0, fl} < FLOORS_V;
  assign up_ok    = ({1'b0, fl} + 5'd1) < FLOORS_V;
  assign dn_ok    = in_range && (fl != 4'd0);

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // map kind to an operation, turning requests that do nothing into OP_NONE
  always_comb begin
    push_cmd.floor = fl;
    push_cmd.dir   = dir;
    case (in_tuser)
      ersu_pkg::KIND_CABIN: push_cmd.op = in_range ? ersu_pkg::OP_CABIN : ersu_pkg::OP_NONE;
      ersu_pkg::KIND_UP:    push_cmd.op = up_ok ? ersu_pkg::OP_UP : ersu_pkg::OP_NONE;
      ersu_pkg::KIND_DOWN:  push_cmd.op = dn_ok ? ersu_pkg::OP_DOWN : ersu_pkg::OP_NONE;
      ersu_pkg::KIND_CLEAR: push_cmd.op = in_range ? ersu_pkg::OP_CLEAR : ersu_pkg::OP_NONE;
      ersu_pkg::KIND_SCHED: push_cmd.op = in_range ? ersu_pkg::OP_SCHED : ersu_pkg::OP_NONE;
      default:              push_cmd.op = ersu_pkg::OP_NONE;
    endcase
  end

endmodule

@@ src/ersu_fifo.sv @@
// Two-entry command queue between front and back.
// Depends on ersu_pkg.
`timescale 1ns / 1ps

module ersu_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ersu_pkg::cmd_t        push_cmd,
  input  logic                  pop,
  output ersu_pkg::cmd_t        pop_cmd,
  output ersu_pkg::queue_stat_t q_stat
);

  ersu_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           wr_ptr_nxt;
  logic           rd_ptr_nxt;
  logic [1:0]     count_nxt;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd          = mem_r[rd_ptr_r];
  assign q_stat.not_empty = count_r != 2'd0;
  assign q_stat.full      = count_r == 2'd2;

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/ersu_back.sv @@
// Back end: request maps, the floor scan sequencer and the result register.
// Depends on ersu_pkg and elevator_request_scheduler_unit_macros.svh.
`timescale 1ns / 1ps
`include "elevator_request_scheduler_unit_macros.svh"

module ersu_back #(
  parameter int FLOORS = ersu_pkg::DEFAULT_FLOORS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ersu_pkg::cmd_t         q_cmd,
  input  ersu_pkg::queue_stat_t  q_stat,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [3:0] target, [5:4] direction_out, [7:6] zero
  output logic [0:0]             out_tuser   // [0] has_target
);

  localparam int         FLOOR_W   = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam logic [4:0] FLOORS_V  = 5'(FLOORS);
  localparam logic [3:0] LAST_STEP = 4'(FLOORS - 1);

  ersu_pkg::state_t  state_r, state_nxt;
  logic [FLOORS-1:0] cab_r, cab_nxt;
  logic [FLOORS-1:0] up_r, up_nxt;
  logic [FLOORS-1:0] dn_r, dn_nxt;
  logic              held_r, held_nxt;
  logic [3:0]        target_r, target_nxt;
  logic [3:0]        cur_r, cur_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              sec_found_r, sec_found_nxt;
  logic [3:0]        sec_floor_r, sec_floor_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_has_r, out_has_nxt;
  logic [3:0]        out_target_r, out_target_nxt;
  logic [1:0]        out_dir_r, out_dir_nxt;

  logic [FLOORS-1:0] pending;
  logic [FLOORS-1:0] fmask;
  logic [4:0]        above_sum;
  logic [3:0]        below_f;
  logic              pend_above;
  logic              pend_below;
  logic              mv_up;
  logic              moving;
  logic              q_moving;
  logic              pri_hit;
  logic              sec_hit;
  logic [3:0]        pri_floor;
  logic [3:0]        sec_floor;
  logic              out_free;
  logic              scan_done;
  logic              scan_found;
  logic [3:0]        scan_floor;
  logic [1:0]        scan_dir;
  logic              scan_rec_sec;
  logic              pop_sched;

  assign pending = cab_r | up_r | dn_r;
  assign fmask   = {{(FLOORS-1){1'b0}}, 1'b1} << q_cmd.floor;

  // floors at the current scan distance, above and below the car
  assign above_sum  = {1'b0, cur_r} + {1'b0, step_r};
  assign below_f    = cur_r - step_r;
  assign pend_above = (above_sum < FLOORS_V) && pending[above_sum[FLOOR_W-1:0]];
  assign pend_below = (step_r <= cur_r) && pending[below_f[FLOOR_W-1:0]];

  assign mv_up    = dir_r == ersu_pkg::TRAVEL_UP;
  assign moving   = mv_up || (dir_r == ersu_pkg::TRAVEL_DOWN);
  assign q_moving = (q_cmd.dir == ersu_pkg::TRAVEL_UP) || (q_cmd.dir == ersu_pkg::TRAVEL_DOWN);

  // primary side is the travel direction, secondary the reverse
  assign pri_hit   = mv_up ? pend_above : pend_below;
  assign sec_hit   = mv_up ? pend_below : pend_above;
  assign pri_floor = mv_up ? above_sum[3:0] : below_f;
  assign sec_floor = mv_up ? below_f : above_sum[3:0];

  assign out_free = !out_valid_r || out_tready;

  // one scan step: decide whether this distance ends the search
  always_comb begin
    scan_done    = 1'b0;
    scan_found   = 1'b0;
    scan_floor   = 4'd0;
    scan_dir     = ersu_pkg::TRAVEL_IDLE;
    scan_rec_sec = 1'b0;
    if (!moving) begin
      if (pend_above) begin
        scan_found = 1'b1;
        scan_floor = above_sum[3:0];
        scan_dir   = (step_r == 4'd0) ? ersu_pkg::TRAVEL_IDLE : ersu_pkg::TRAVEL_UP;
      end else if ((step_r != 4'd0) && pend_below) begin
        scan_found = 1'b1;
        scan_floor = below_f;
        scan_dir   = ersu_pkg::TRAVEL_DOWN;
      end
    end else if (pri_hit) begin
      scan_found = 1'b1;
      scan_floor = pri_floor;
      scan_dir   = dir_r;
    end else begin
      scan_rec_sec = sec_hit && !sec_found_r;
    end
    if (scan_found) begin
      scan_done = 1'b1;
    end else if (step_r == LAST_STEP) begin
      scan_done = 1'b1;
      // nothing ahead: turn around toward the nearest floor behind
      if (moving && (sec_found_r || sec_hit)) begin
        scan_found = 1'b1;
        scan_floor = sec_found_r ? sec_floor_r : sec_floor;
        scan_dir   = mv_up ? ersu_pkg::TRAVEL_DOWN : ersu_pkg::TRAVEL_UP;
      end
    end
  end

  // sequencer: pop and apply commands, run the scan, load results
  always_comb begin
    state_nxt      = state_r;
    cab_nxt        = cab_r;
    up_nxt         = up_r;
    dn_nxt         = dn_r;
    held_nxt       = held_r;
    target_nxt     = target_r;
    cur_nxt        = cur_r;
    dir_nxt        = dir_r;
    step_nxt       = step_r;
    sec_found_nxt  = sec_found_r;
    sec_floor_nxt  = sec_floor_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_has_nxt    = out_has_r;
    out_target_nxt = out_target_r;
    out_dir_nxt    = out_dir_r;
    q_pop          = 1'b0;
    case (state_r)
      ersu_pkg::ST_IDLE: begin
        if (q_stat.not_empty && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            ersu_pkg::OP_CABIN: cab_nxt = cab_r | fmask;
            ersu_pkg::OP_UP:    up_nxt  = up_r | fmask;
            ersu_pkg::OP_DOWN:  dn_nxt  = dn_r | fmask;
            ersu_pkg::OP_CLEAR: begin
              cab_nxt = cab_r & ~fmask;
              up_nxt  = up_r & ~fmask;
              dn_nxt  = dn_r & ~fmask;
            end
            ersu_pkg::OP_SCHED: begin
              cur_nxt       = q_cmd.floor;
              dir_nxt       = q_cmd.dir;
              step_nxt      = q_moving ? 4'd1 : 4'd0;
              sec_found_nxt = 1'b0;
              state_nxt     = ersu_pkg::ST_SCAN;
            end
            default: ;
          endcase
          // everything but a schedule answers at once
          if (q_cmd.op != ersu_pkg::OP_SCHED) begin
            out_valid_nxt  = 1'b1;
            out_has_nxt    = held_r;
            out_target_nxt = target_r;
            out_dir_nxt    = q_cmd.dir;
          end
        end
      end
      ersu_pkg::ST_SCAN: begin
        step_nxt = step_r + 4'd1;
        if (scan_rec_sec) begin
          sec_found_nxt = 1'b1;
          sec_floor_nxt = sec_floor;
        end
        if (scan_done) begin
          held_nxt       = scan_found;
          target_nxt     = scan_floor;
          out_valid_nxt  = 1'b1;
          out_has_nxt    = scan_found;
          out_target_nxt = scan_floor;
          out_dir_nxt    = scan_dir;
          state_nxt      = ersu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ersu_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ersu_pkg::ST_IDLE;
      cab_r       <= '0;
      up_r        <= '0;
      dn_r        <= '0;
      held_r      <= 1'b0;
      target_r    <= 4'd0;
      sec_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cab_r       <= cab_nxt;
      up_r        <= up_nxt;
      dn_r        <= dn_nxt;
      held_r      <= held_nxt;
      target_r    <= target_nxt;
      sec_found_r <= sec_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // scan context and result payload
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    dir_r        <= dir_nxt;
    step_r       <= step_nxt;
    sec_floor_r  <= sec_floor_nxt;
    out_has_r    <= out_has_nxt;
    out_target_r <= out_target_nxt;
    out_dir_r    <= out_dir_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {2'b00, out_dir_r, out_target_r};
  assign out_tuser[0] = out_has_r;

  // a schedule command leaving the queue
  assign pop_sched = q_pop && (q_cmd.op == ersu_pkg::OP_SCHED);

  `ERSU_ASSERT_NOW(a_pop_only_idle, q_pop, state_r == ersu_pkg::ST_IDLE)
  `ERSU_ASSERT_NOW(a_scan_no_result, state_r == ersu_pkg::ST_SCAN, !out_valid_r)
  `ERSU_ASSERT_NOW(a_step_bound, state_r == ersu_pkg::ST_SCAN, step_r <= LAST_STEP)
  `ERSU_ASSERT_NOW(a_no_target_zero, !held_r, target_r == 4'd0)
  `ERSU_ASSERT_NEXT(a_sched_enters_scan, pop_sched, state_r == ersu_pkg::ST_SCAN)

endmodule

@@ src/elevator_request_scheduler_unit.sv @@
// Order: a request or clear beat passes through the command queue to the back end, which
// registers its result; a schedule beat first runs the scan, one floor distance per cycle.
// Throughput: one request or clear beat per cycle unless the output stalls or a scan runs;
// a schedule stalls the back end for its scan, while the two-entry queue accepts until full.
// Reset: synchronous, active low; clears all request maps, the held target, the command
// queue and the result valid flag.
`timescale 1ns / 1ps

module elevator_request_scheduler_unit #(
  parameter int FLOORS = ersu_pkg::DEFAULT_FLOORS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] floor, [5:4] direction_in, [7:6] zero
  input  logic [2:0] in_tuser,   // [2:0] kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [3:0] target, [5:4] direction_out, [7:6] zero
  output logic [0:0] out_tuser   // [0] has_target
);

  ersu_pkg::queue_stat_t q_stat;
  ersu_pkg::cmd_t        push_cmd;
  ersu_pkg::cmd_t        pop_cmd;
  logic                  push;
  logic                  pop;

  // classify incoming beats
  ersu_front #(.FLOORS(FLOORS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decoupling queue
  ersu_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  // request maps, scan and result register
  ersu_back #(.FLOORS(FLOORS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (pop_cmd),
    .q_stat     (q_stat),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ bench/ersu_result_checker.sv @@
// Result checker for the elevator request scheduler: watches both stream channels,
// predicts each result from the accepted request beats and compares them in order.
// Depends on ersu_pkg for kind codes, directions and field widths.
`timescale 1ns / 1ps

module ersu_result_checker #(
  parameter int FLOORS = ersu_pkg::DEFAULT_FLOORS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] floor, [5:4] direction_in, [7:6] zero
  input  logic [2:0] in_tuser,   // [2:0] kind
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [3:0] target, [5:4] direction_out, [7:6] zero
  input  logic [0:0] out_tuser,  // [0] has_target
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic                            has_target;
    logic [ersu_pkg::FLOOR_BITS-1:0] target;
    logic [ersu_pkg::DIR_BITS-1:0]   dir;
  } sched_result_t;

  // shadow copy of the scheduler state
  logic [FLOORS-1:0]               cabin_map;
  logic [FLOORS-1:0]               up_map;
  logic [FLOORS-1:0]               down_map;
  logic                            target_valid;
  logic [ersu_pkg::FLOOR_BITS-1:0] held_floor;

  sched_result_t expected_results[$];
  int            errs;

  initial begin
    fail_count = 0;
    pending    = 0;
    errs       = 0;
  end

  function automatic void hold_target(int f);
    if (f < 0) begin
      target_valid = 1'b0;
      held_floor   = '0;
    end else begin
      target_valid = 1'b1;
      held_floor   = f[ersu_pkg::FLOOR_BITS-1:0];
    end
  endfunction

  // first busy floor strictly above or below cur, -1 if none
  function automatic int nearest_pending(logic [FLOORS-1:0] busy, int cur, bit go_up);
    if (go_up) begin
      for (int f = cur + 1; f < FLOORS; f++)
        if (busy[f]) return f;
    end else begin
      for (int f = cur - 1; f >= 0; f--)
        if (busy[f]) return f;
    end
    return -1;
  endfunction

  // LOOK-style choice of the next target; returns the new direction
  function automatic logic [ersu_pkg::DIR_BITS-1:0] plan_next(
      int cur, logic [ersu_pkg::DIR_BITS-1:0] dir);
    logic [FLOORS-1:0] busy;
    int                hit;
    busy = cabin_map | up_map | down_map;
    if (busy == '0) begin
      hold_target(-1);
      return ersu_pkg::TRAVEL_IDLE;
    end
    // idle (or unknown direction): nearest floor, above wins a tie
    if (dir != ersu_pkg::TRAVEL_UP && dir != ersu_pkg::TRAVEL_DOWN) begin
      for (int r = 0; r < FLOORS; r++) begin
        if (cur + r < FLOORS && busy[cur+r]) begin
          hold_target(cur + r);
          return (r > 0) ? ersu_pkg::TRAVEL_UP : ersu_pkg::TRAVEL_IDLE;
        end
        if (r > 0 && cur - r >= 0 && busy[cur-r]) begin
          hold_target(cur - r);
          return ersu_pkg::TRAVEL_DOWN;
        end
      end
      hold_target(-1);
      return ersu_pkg::TRAVEL_IDLE;
    end
    // moving: keep going, else reverse, else stop
    hit = nearest_pending(busy, cur, dir == ersu_pkg::TRAVEL_UP);
    if (hit >= 0) begin
      hold_target(hit);
      return dir;
    end
    hit = nearest_pending(busy, cur, dir != ersu_pkg::TRAVEL_UP);
    if (hit >= 0) begin
      hold_target(hit);
      return (dir == ersu_pkg::TRAVEL_UP) ? ersu_pkg::TRAVEL_DOWN : ersu_pkg::TRAVEL_UP;
    end
    hold_target(-1);
    return ersu_pkg::TRAVEL_IDLE;
  endfunction

  function automatic sched_result_t apply_beat(logic [ersu_pkg::KIND_BITS-1:0] kind,
                                               logic [ersu_pkg::FLOOR_BITS-1:0] fl,
                                               logic [ersu_pkg::DIR_BITS-1:0] dir);
    sched_result_t     res;
    logic              in_range;
    logic [FLOORS-1:0] sel;
    in_range = (fl < FLOORS);
    sel      = in_range ? ({{(FLOORS-1){1'b0}}, 1'b1} << fl) : '0;
    res.dir  = dir;
    case (kind)
      ersu_pkg::KIND_CABIN: cabin_map = cabin_map | sel;
      ersu_pkg::KIND_UP:    if (fl + 1 < FLOORS) up_map = up_map | sel;
      ersu_pkg::KIND_DOWN:  if (fl > 0) down_map = down_map | sel;
      ersu_pkg::KIND_CLEAR: begin
        cabin_map = cabin_map & ~sel;
        up_map    = up_map & ~sel;
        down_map  = down_map & ~sel;
      end
      ersu_pkg::KIND_SCHED: if (in_range) res.dir = plan_next(int'(fl), dir);
      default: ;
    endcase
    res.has_target = target_valid;
    res.target     = target_valid ? held_floor : '0;
    return res;
  endfunction

  // track accepted beats on both sides
  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst_n) begin
      cabin_map    = '0;
      up_map       = '0;
      down_map     = '0;
      target_valid = 1'b0;
      held_floor   = '0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_beat(in_tuser, in_tdata[3:0], in_tdata[5:4]));
      if (out_tvalid && out_tready) begin
        got.has_target = out_tuser[0];
        got.target     = out_tdata[3:0];
        got.dir        = out_tdata[5:4];
        if (expected_results.size() == 0) begin
          if (errs < 10)
            $display("unexpected result beat: has=%0d tgt=%0d dir=%0d",
                     got.has_target, got.target, got.dir);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.has_target !== want.has_target || got.target !== want.target ||
              got.dir !== want.dir) begin
            if (errs < 10)
              $display("mismatch: expected has=%0d tgt=%0d dir=%0d, got has=%0d tgt=%0d dir=%0d",
                       want.has_target, want.target, want.dir,
                       got.has_target, got.target, got.dir);
            errs++;
          end
        end
      end
    end
    pending    <= expected_results.size();
    fail_count <= errs;
  end

endmodule

@@ bench/tb_elevator_request_scheduler_unit.sv @@
// Testbench top for elevator_request_scheduler_unit: drives request and schedule beats
// with varying idle and stall patterns, and gives the verdict from ersu_result_checker.
// Depends on ersu_pkg, the scheduler RTL and bench/ersu_result_checker.sv.
`timescale 1ns / 1ps

module tb_elevator_request_scheduler_unit;

  localparam int FLOORS       = ersu_pkg::DEFAULT_FLOORS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_BEATS  = 425;
  localparam int TAIL_CYCLES  = 2 * (2 + FLOORS) + 4;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [3:0] floor, [5:4] direction_in, [7:6] zero
  logic [2:0] in_tuser   = '0;   // [2:0] kind
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [3:0] target, [5:4] direction_out, [7:6] zero
  logic [0:0] out_tuser;         // [0] has_target

  int fail_count;
  int pending;
  int cycle_count = 0;
  int tx_gap_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left   = 0;
  bit backpressure_req  = 1'b0;
  bit backpressure_done = 1'b0;

  elevator_request_scheduler_unit #(.FLOORS(FLOORS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ersu_result_checker #(.FLOORS(FLOORS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result sink: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (backpressure_req && !backpressure_done) begin
      out_tready        <= 1'b0;
      hold_left         <= HOLD_CYCLES;
      backpressure_done <= 1'b1;
    end else begin
      out_tready <= !($urandom_range(99) < rx_stall_pct);
    end
  end

  // offer one beat, with random idle cycles ahead of it
  task automatic send_beat(logic [2:0] kind, logic [3:0] fl, logic [1:0] dir);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, dir, fl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // mostly in-range requests and schedules, some stray floors and unknown kinds
  task automatic send_random_beat();
    int          roll;
    logic [2:0]  kind;
    logic [3:0]  fl;
    logic [1:0]  dir;
    roll = $urandom_range(99);
    if (roll < 18)      kind = ersu_pkg::KIND_CABIN;
    else if (roll < 30) kind = ersu_pkg::KIND_UP;
    else if (roll < 42) kind = ersu_pkg::KIND_DOWN;
    else if (roll < 55) kind = ersu_pkg::KIND_CLEAR;
    else if (roll < 95) kind = ersu_pkg::KIND_SCHED;
    else                kind = 3'($urandom_range(7, 5));
    if ($urandom_range(99) < 88) fl = 4'($urandom_range(FLOORS - 1));
    else                         fl = 4'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 35)      dir = ersu_pkg::TRAVEL_IDLE;
    else if (roll < 65) dir = ersu_pkg::TRAVEL_UP;
    else if (roll < 95) dir = ersu_pkg::TRAVEL_DOWN;
    else                dir = 2'd3;
    send_beat(kind, fl, dir);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty maps, ignored requests, nearest pick, reversal, unknown codes
    send_beat(ersu_pkg::KIND_SCHED, 4'd0, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_CABIN, 4'd15, ersu_pkg::TRAVEL_UP);
    send_beat(ersu_pkg::KIND_UP, 4'(FLOORS - 1), ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_DOWN, 4'd0, ersu_pkg::TRAVEL_DOWN);
    send_beat(ersu_pkg::KIND_CABIN, 4'd0, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_UP, 4'd0, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_DOWN, 4'(FLOORS - 1), ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_SCHED, 4'd1, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_SCHED, 4'd1, ersu_pkg::TRAVEL_UP);
    send_beat(ersu_pkg::KIND_SCHED, 4'd2, ersu_pkg::TRAVEL_DOWN);
    send_beat(ersu_pkg::KIND_CLEAR, 4'd0, ersu_pkg::TRAVEL_IDLE);
    // only the current floor is pending while moving up
    send_beat(ersu_pkg::KIND_SCHED, 4'(FLOORS - 1), ersu_pkg::TRAVEL_UP);
    send_beat(ersu_pkg::KIND_SCHED, 4'(FLOORS - 1), ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_SCHED, 4'(FLOORS - 1), 2'd3);
    send_beat(ersu_pkg::KIND_CLEAR, 4'd15, ersu_pkg::TRAVEL_IDLE);
    send_beat(3'd5, 4'd2, ersu_pkg::TRAVEL_UP);
    send_beat(3'd6, 4'd15, 2'd3);
    send_beat(3'd7, 4'd0, ersu_pkg::TRAVEL_DOWN);
    send_beat(ersu_pkg::KIND_SCHED, 4'd15, ersu_pkg::TRAVEL_UP);
    send_beat(ersu_pkg::KIND_CABIN, 4'(FLOORS - 1), ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_UP, 4'd2, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_SCHED, 4'd0, ersu_pkg::TRAVEL_DOWN);
    send_beat(ersu_pkg::KIND_CLEAR, 4'(FLOORS - 1), ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_CLEAR, 4'd2, ersu_pkg::TRAVEL_IDLE);
    send_beat(ersu_pkg::KIND_SCHED, 4'd1, ersu_pkg::TRAVEL_UP);

    // random phases: free running, sender idle, sink stalling, both light
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_gap_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_gap_pct <= 73; rx_stall_pct <= 0;  end
        2: begin tx_gap_pct <= 0;  rx_stall_pct <= 73; end
        default: begin tx_gap_pct <= 6; rx_stall_pct <= 6; end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (phase == 0 && n == 50) backpressure_req <= 1'b1;
        send_random_beat();
      end
    end
    in_tvalid <= 1'b0;

    // drain, then a short tail for anything stray
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
